// File: design/gmma_pkg.sv
// ----------------------------------------------------------------------------
// Grouped min/max/average package
// Shared widths, mode and register codes, and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package gmma_pkg;

  localparam int MaxCountDef = 4096;

  localparam int MonthW    = 4;
  localparam int ReadW     = 8;
  localparam int CountOutW = 13;
  localparam int ModeW     = 2;
  localparam int CfgIdxW   = 4;
  localparam int CfgDataW  = 8;

  localparam logic [ModeW-1:0] MODE_CONSEC = 2'd0;
  localparam logic [ModeW-1:0] MODE_SELECT = 2'd1;
  localparam logic [ModeW-1:0] MODE_ALL    = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_MODE      = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_SEL_MONTH = 4'd1;

  localparam logic [MonthW-1:0] SEL_MONTH_RST = 4'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_FOLD,
    S_START,
    S_DIV,
    S_EMIT
  } state_e;

endpackage

`default_nettype wire

// File: design/gmma_intf.sv
// ----------------------------------------------------------------------------
// Grouped min/max/average channel interfaces
// Record input, result output and register write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface gmma_rec_if;
  import gmma_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [MonthW-1:0]        record_month;
  logic signed [ReadW-1:0]  reading;
  logic                     end_of_data;

  modport source (output valid, record_month, reading, end_of_data, input ready);
  modport sink   (input valid, record_month, reading, end_of_data, output ready);
endinterface

interface gmma_res_if;
  import gmma_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [MonthW-1:0]        group_month;
  logic signed [ReadW-1:0]  lowest;
  logic signed [ReadW-1:0]  highest;
  logic signed [ReadW-1:0]  average;
  logic [CountOutW-1:0]     sample_count;
  logic                     empty_res;
  logic                     overflowed;
  logic                     last_result;

  modport source (output valid, group_month, lowest, highest, average, sample_count,
                  empty_res, overflowed, last_result, input ready);
  modport sink   (input valid, group_month, lowest, highest, average, sample_count,
                  empty_res, overflowed, last_result, output ready);
endinterface

interface gmma_cfg_if;
  import gmma_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CfgIdxW-1:0]   index;
  logic [CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: design/gmma_div.sv
// ----------------------------------------------------------------------------
// Grouped min/max/average divider
// Restoring unsigned divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gmma_div #(
  parameter int DividendW = 21,
  parameter int DivisorW  = 13
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [DividendW-1:0] dividend_i,
  input  wire logic [DivisorW-1:0]  divisor_i,
  output logic                      done_o,
  output logic [DividendW-1:0]      quotient_o
);

  localparam int StepW = $clog2(DividendW);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [StepW-1:0]     step_q, step_d;
  logic [DivisorW:0]    rem_q, rem_d;
  logic [DividendW-1:0] quo_q, quo_d;
  logic [DivisorW-1:0]  dvs_q, dvs_d;

  logic [DivisorW:0]    rem_sh;
  logic                 fits;
  logic                 last_step;

  assign rem_sh    = {rem_q[DivisorW-1:0], quo_q[DividendW-1]};
  assign fits      = rem_sh >= {1'b0, dvs_q};
  assign last_step = step_q == StepW'(DividendW - 1);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = fits ? rem_sh - {1'b0, dvs_q} : rem_sh;
      quo_d  = {quo_q[DividendW-2:0], fits};
      step_d = step_q + StepW'(1);
      if (last_step) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// File: design/grouped_min_max_average.sv
// ----------------------------------------------------------------------------
// Grouped min/max/average
// Folds temperature records into a running group and reports minimum,
// maximum, truncated average and count when a group closes.
// ----------------------------------------------------------------------------
// An item that closes no group passes through the decide and fold states only.
// Each result waits on the bit-serial divider that forms the average; an item may
// cause two results.
// The output register lets the next record be taken while a result waits.
// Reset clears the registers to mode 0 and selected month 1, with no group open.
// ----------------------------------------------------------------------------
`default_nettype none

module grouped_min_max_average #(
  parameter int MAX_COUNT = gmma_pkg::MaxCountDef
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  gmma_rec_if.sink    rec_i,
  gmma_res_if.source  res_o,
  gmma_cfg_if.sink    cfg_i
);
  import gmma_pkg::*;

  localparam int CntW = $clog2(MAX_COUNT + 1);
  localparam int SumW = CntW + ReadW;

  state_e state_q, state_d;

  logic [ModeW-1:0]        mode_q, mode_d;
  logic [MonthW-1:0]       sel_q, sel_d;

  logic [MonthW-1:0]       in_month_q;
  logic signed [ReadW-1:0] in_read_q;
  logic                    in_eod_q;

  logic [MonthW-1:0]       cur_month_q, cur_month_d;
  logic signed [ReadW-1:0] low_q, low_d;
  logic signed [ReadW-1:0] high_q, high_d;
  logic signed [SumW-1:0]  sum_q, sum_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic                    open_q, open_d;
  logic                    ovf_q, ovf_d;
  logic                    phase_q, phase_d;

  logic                    out_valid_q, out_valid_d;
  logic [MonthW-1:0]       o_month_q;
  logic signed [ReadW-1:0] o_low_q, o_high_q, o_avg_q;
  logic [CountOutW-1:0]    o_cnt_q;
  logic                    o_empty_q, o_ovf_q, o_last_q;

  logic rec_ready, cfg_ready, rec_xfer, cfg_xfer;
  logic div_start, div_done, out_load;
  logic need_pre, fold_en, grp_empty;
  logic [SumW-1:0]         sum_mag;
  logic [SumW-1:0]         quotient;
  logic [ReadW-1:0]        q_low;
  logic signed [ReadW-1:0] avg;
  logic [MonthW-1:0]       emit_month;

  assign rec_xfer  = rec_i.valid && rec_ready;
  assign cfg_xfer  = cfg_i.valid && cfg_ready;
  assign need_pre  = (mode_q == MODE_CONSEC) && open_q && (in_month_q != cur_month_q);
  assign fold_en   = (mode_q != MODE_SELECT) || (in_month_q == sel_q);
  assign grp_empty = cnt_q == '0;
  assign sum_mag   = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
  assign q_low     = quotient[ReadW-1:0];
  assign avg       = sum_q[SumW-1] ? $signed(ReadW'(-q_low)) : $signed(q_low);

  always_comb begin
    case (mode_q)
      MODE_CONSEC: emit_month = cur_month_q;
      MODE_SELECT: emit_month = sel_q;
      default:     emit_month = '0;
    endcase
  end

  gmma_div #(
    .DividendW (SumW),
    .DivisorW  (CntW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_mag),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Sequencer outputs.
  always_comb begin
    rec_ready = 1'b0;
    cfg_ready = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        cfg_ready = 1'b1;
        rec_ready = !cfg_i.valid;
      end
      S_START: div_start = 1'b1;
      S_EMIT:  out_load  = !out_valid_q || res_o.ready;
      default: ;
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (rec_xfer) state_d = S_DECIDE;
      S_DECIDE: state_d = need_pre ? S_START : S_FOLD;
      S_FOLD:   state_d = in_eod_q ? S_START : S_IDLE;
      S_START:  state_d = S_DIV;
      S_DIV:    if (div_done) state_d = S_EMIT;
      S_EMIT: begin
        if (out_load) state_d = phase_q ? S_IDLE : S_FOLD;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // Running group and registers.
  always_comb begin
    mode_d      = mode_q;
    sel_d       = sel_q;
    cur_month_d = cur_month_q;
    low_d       = low_q;
    high_d      = high_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    open_d      = open_q;
    ovf_d       = ovf_q;
    phase_d     = phase_q;

    if (state_q == S_DECIDE) begin
      phase_d = 1'b0;
    end

    if (state_q == S_FOLD) begin
      phase_d = 1'b1;
      if (mode_q == MODE_CONSEC && !open_q) begin
        open_d      = 1'b1;
        cur_month_d = in_month_q;
      end
      if (fold_en) begin
        if (cnt_q >= CntW'(MAX_COUNT)) begin
          ovf_d = 1'b1;
        end else begin
          if (grp_empty) begin
            low_d  = in_read_q;
            high_d = in_read_q;
          end else begin
            if (in_read_q < low_q)  low_d  = in_read_q;
            if (in_read_q > high_q) high_d = in_read_q;
          end
          sum_d = sum_q + SumW'(in_read_q);
          cnt_d = cnt_q + CntW'(1);
        end
      end
    end

    if (cfg_xfer && (cfg_i.index == CFG_MODE || cfg_i.index == CFG_SEL_MONTH)) begin
      if (cfg_i.index == CFG_MODE) begin
        mode_d = cfg_i.data[ModeW-1:0];
      end else begin
        sel_d = cfg_i.data[MonthW-1:0];
      end
    end

    if (out_load ||
        (cfg_xfer && (cfg_i.index == CFG_MODE || cfg_i.index == CFG_SEL_MONTH))) begin
      cur_month_d = '0;
      low_d       = '0;
      high_d      = '0;
      sum_d       = '0;
      cnt_d       = '0;
      open_d      = 1'b0;
      ovf_d       = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_CONSEC;
      sel_q       <= SEL_MONTH_RST;
      cur_month_q <= '0;
      low_q       <= '0;
      high_q      <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      open_q      <= 1'b0;
      ovf_q       <= 1'b0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      sel_q       <= sel_d;
      cur_month_q <= cur_month_d;
      low_q       <= low_d;
      high_q      <= high_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      open_q      <= open_d;
      ovf_q       <= ovf_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_xfer) begin
      in_month_q <= rec_i.record_month;
      in_read_q  <= rec_i.reading;
      in_eod_q   <= rec_i.end_of_data;
    end
    if (out_load) begin
      o_month_q <= emit_month;
      o_low_q   <= grp_empty ? '0 : low_q;
      o_high_q  <= grp_empty ? '0 : high_q;
      o_avg_q   <= grp_empty ? '0 : avg;
      o_cnt_q   <= grp_empty ? '0 : CountOutW'(cnt_q);
      o_empty_q <= grp_empty;
      o_ovf_q   <= ovf_q;
      o_last_q  <= phase_q || !in_eod_q;
    end
  end

  assign rec_i.ready        = rec_ready;
  assign cfg_i.ready        = cfg_ready;
  assign res_o.valid        = out_valid_q;
  assign res_o.group_month  = o_month_q;
  assign res_o.lowest       = o_low_q;
  assign res_o.highest      = o_high_q;
  assign res_o.average      = o_avg_q;
  assign res_o.sample_count = o_cnt_q;
  assign res_o.empty_res    = o_empty_q;
  assign res_o.overflowed   = o_ovf_q;
  assign res_o.last_result  = o_last_q;

endmodule

`default_nettype wire

// File: design/gmma_checker.sv
// ----------------------------------------------------------------------------
// Grouped min/max/average checker
// Port-level assertions on the result channel and the record handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module gmma_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              rec_valid_i,
  input wire logic                              rec_ready_i,
  input wire logic                              res_valid_i,
  input wire logic                              res_ready_i,
  input wire logic signed [gmma_pkg::ReadW-1:0] lowest_i,
  input wire logic signed [gmma_pkg::ReadW-1:0] highest_i,
  input wire logic signed [gmma_pkg::ReadW-1:0] average_i,
  input wire logic [gmma_pkg::CountOutW-1:0]    sample_count_i,
  input wire logic                              empty_res_i
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result valid dropped before its transfer");

  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(lowest_i) && $stable(highest_i) &&
      $stable(average_i) && $stable(sample_count_i) && $stable(empty_res_i))
    else $error("result payload changed while stalled");

  a_busy_after_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid_i && rec_ready_i |=> !rec_ready_i)
    else $error("record taken while the previous one is still in work");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && empty_res_i |-> lowest_i == '0 && highest_i == '0 &&
      average_i == '0 && sample_count_i == '0)
    else $error("empty group carries nonzero statistics");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !empty_res_i |-> lowest_i <= highest_i &&
      lowest_i <= average_i && average_i <= highest_i && sample_count_i != '0)
    else $error("group statistics out of order");

endmodule

bind grouped_min_max_average gmma_checker u_gmma_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .rec_valid_i    (rec_i.valid),
  .rec_ready_i    (rec_i.ready),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .lowest_i       (res_o.lowest),
  .highest_i      (res_o.highest),
  .average_i      (res_o.average),
  .sample_count_i (res_o.sample_count),
  .empty_res_i    (res_o.empty_res)
);

`default_nettype wire
